// ----- design/fpsf_pkg.sv -----
// Package for the five-point sharpen filter.
// Holds payload structs, field widths, register indexes and the stencil item type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpsf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int FRAC_W     = 12;
	localparam int LAP_W      = SAMPLE_W + 3;
	localparam int STR_W      = 16;
	localparam int PROD_W     = LAP_W + STR_W + 1;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int MAX_ROWS   = 4096;
	localparam int MIN_SIZE   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PAIR_W     = 2 * SAMPLE_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_STRENGTH     = 2'd2
	} fpsf_cfg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] height_in;
		logic                       start_of_frame;
	} fpsf_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] height_out;
		logic [COL_W-1:0]           column_out;
		logic [ROW_W-1:0]           row_out;
		logic                       last_of_run;
	} fpsf_out_t;

	typedef struct packed {
		logic inner;
		logic border;
	} fpsf_flags_t;

	typedef struct packed {
		logic signed [LAP_W-1:0]    lap;
		logic signed [SAMPLE_W-1:0] center;
		logic signed [SAMPLE_W-1:0] sample;
		logic [COL_W-1:0]           col;
		logic [ROW_W-1:0]           row;
		fpsf_flags_t                flags;
	} fpsf_kitem_t;

endpackage

`default_nettype wire

// ----- design/fpsf_line_store.sv -----
// Two line stores held as one memory of sample pairs {newer row, older row}.
// Unwritten entries read as zero through a fill mark; same-cycle writes are forwarded.
// Depends on fpsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpsf_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               rd_addr,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [fpsf_pkg::PAIR_W-1:0] wr_data,
	output logic [fpsf_pkg::PAIR_W-1:0]      rd_data
);
	import fpsf_pkg::*;

	logic [PAIR_W-1:0] mem [DEPTH];
	logic [PAIR_W-1:0] raw_q;
	logic [PAIR_W-1:0] fwd_data_q;
	logic              fwd_q;
	logic              vld_q;
	logic [AW:0]       fill_q;
	logic              fwd_c;

	assign fwd_c = wr_en && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q      <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			fwd_q  <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (wr_en && ({1'b0, wr_addr} == fill_q)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (rd_en) begin
				fwd_q <= fwd_c;
				vld_q <= ({1'b0, rd_addr} < fill_q);
			end
		end
	end

	always_comb begin
		if (fwd_q) begin
			rd_data = fwd_data_q;
		end else if (vld_q) begin
			rd_data = raw_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

`default_nettype wire

// ----- design/fpsf_position.sv -----
// Column and row counters for the incoming sample, with size clamping and wrap.
// Gives the current position and its border and interior flags.
// Depends on fpsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpsf_position #(
	parameter int MAX_WIDTH = 1024,
	parameter int AW        = 10
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      advance,
	input  wire logic                      sof,
	input  wire logic [fpsf_pkg::FW_W-1:0] frame_width,
	input  wire logic [fpsf_pkg::FH_W-1:0] frame_height,
	output logic [AW-1:0]                  x,
	output logic [fpsf_pkg::ROW_W-1:0]     y,
	output fpsf_pkg::fpsf_flags_t          flags
);
	import fpsf_pkg::*;

	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [31:0]      fw_wide;
	logic [31:0]      ew_wide;
	logic [AW:0]      eff_w;
	logic [FH_W-1:0]  eff_h;
	logic [AW-1:0]    col_pre;
	logic [ROW_W-1:0] row_pre;
	logic             col_wrap;
	logic [FH_W-1:0]  row_t;
	logic [AW:0]      x_inc;
	logic [FH_W-1:0]  y_inc;
	logic             end_row;
	logic             end_frame;

	always_comb begin
		fw_wide = 32'(frame_width);
		if (fw_wide < 32'(MIN_SIZE)) begin
			ew_wide = 32'(MIN_SIZE);
		end else if (fw_wide > 32'(MAX_WIDTH)) begin
			ew_wide = 32'(MAX_WIDTH);
		end else begin
			ew_wide = fw_wide;
		end
		eff_w = ew_wide[AW:0];

		if (frame_height < FH_W'(MIN_SIZE)) begin
			eff_h = FH_W'(MIN_SIZE);
		end else if (frame_height > FH_W'(MAX_ROWS)) begin
			eff_h = FH_W'(MAX_ROWS);
		end else begin
			eff_h = frame_height;
		end

		col_pre  = sof ? '0 : col_q;
		row_pre  = sof ? '0 : row_q;
		col_wrap = ({1'b0, col_pre} >= eff_w);
		x        = col_wrap ? '0 : col_pre;
		row_t    = {1'b0, row_pre} + FH_W'(col_wrap);
		y        = (row_t >= eff_h) ? '0 : row_t[ROW_W-1:0];

		flags.border = (x == '0) || ({1'b0, x} == eff_w - 1'b1) ||
			(y == '0) || ({1'b0, y} == eff_h - 1'b1);
		flags.inner  = (x >= AW'(2)) && (y >= ROW_W'(2));

		x_inc     = {1'b0, x} + 1'b1;
		y_inc     = {1'b0, y} + 1'b1;
		end_row   = (x_inc >= eff_w);
		end_frame = (y_inc >= eff_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_frame ? '0 : y_inc[ROW_W-1:0];
			end else begin
				col_q <= x_inc[AW-1:0];
				row_q <= y;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/fpsf_kernel.sv -----
// Sharpen arithmetic and result sequencing: multiply stage, add/saturate into
// the output register, interior result first and border result second.
// Depends on fpsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpsf_kernel (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       k_valid,
	output logic                            k_ready,
	input  wire fpsf_pkg::fpsf_kitem_t      k_item,
	input  wire logic [fpsf_pkg::STR_W-1:0] strength,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output fpsf_pkg::fpsf_out_t             result_item
);
	import fpsf_pkg::*;

	localparam int SUM_W = PROD_W - FRAC_W + 1;

	fpsf_kitem_t                item_s2;
	logic                       valid_s2;
	logic signed [PROD_W-1:0]   prod_s3;
	logic signed [SAMPLE_W-1:0] center_s3;
	logic signed [SAMPLE_W-1:0] sample_s3;
	logic [COL_W-1:0]           col_s3;
	logic [ROW_W-1:0]           row_s3;
	logic                       pend_int_s3;
	logic                       pend_bord_s3;
	logic                       result_valid_q;
	fpsf_out_t                  result_q;

	logic                       valid_s3;
	logic                       ready_s3;
	logic                       adv2;
	logic                       out_free;
	logic                       load;
	logic                       last_sel;
	logic                       done3;
	logic signed [PROD_W-1:0]   prod_c;
	logic signed [SUM_W-1:0]    sum_c;
	logic signed [SAMPLE_W-1:0] sat_c;
	fpsf_out_t                  next_c;

	assign valid_s3 = pend_int_s3 || pend_bord_s3;
	assign out_free = !result_valid_q || !result_stall;
	assign load     = valid_s3 && out_free;
	assign last_sel = !pend_int_s3 || !pend_bord_s3;
	assign done3    = load && last_sel;
	assign ready_s3 = !valid_s3 || done3;
	assign adv2     = valid_s2 && ready_s3;
	assign k_ready  = !valid_s2 || ready_s3;

	assign prod_c = PROD_W'(item_s2.lap) * PROD_W'($signed({1'b0, strength}));

	always_comb begin
		sum_c = SUM_W'(center_s3) + SUM_W'(prod_s3 >>> FRAC_W);
		if (sum_c > SUM_W'(2 ** (SAMPLE_W - 1) - 1)) begin
			sat_c = {1'b0, {(SAMPLE_W - 1){1'b1}}};
		end else if (sum_c < -SUM_W'(2 ** (SAMPLE_W - 1))) begin
			sat_c = {1'b1, {(SAMPLE_W - 1){1'b0}}};
		end else begin
			sat_c = sum_c[SAMPLE_W-1:0];
		end

		if (pend_int_s3) begin
			next_c.height_out  = sat_c;
			next_c.column_out  = col_s3 - 1'b1;
			next_c.row_out     = row_s3 - 1'b1;
			next_c.last_of_run = !pend_bord_s3;
		end else begin
			next_c.height_out  = sample_s3;
			next_c.column_out  = col_s3;
			next_c.row_out     = row_s3;
			next_c.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (k_valid && k_ready) begin
			item_s2 <= k_item;
		end
		if (adv2) begin
			prod_s3   <= prod_c;
			center_s3 <= item_s2.center;
			sample_s3 <= item_s2.sample;
			col_s3    <= item_s2.col;
			row_s3    <= item_s2.row;
		end
		if (load) begin
			result_q <= next_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			pend_int_s3    <= 1'b0;
			pend_bord_s3   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (k_ready) begin
				valid_s2 <= k_valid;
			end
			if (adv2) begin
				pend_int_s3  <= item_s2.flags.inner;
				pend_bord_s3 <= item_s2.flags.border;
			end else if (done3) begin
				pend_int_s3  <= 1'b0;
				pend_bord_s3 <= 1'b0;
			end else if (load) begin
				pend_int_s3 <= 1'b0;
			end
			if (out_free) begin
				result_valid_q <= valid_s3;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

endmodule

`default_nettype wire

// ----- design/five_point_sharpen_filter_unit.sv -----
// Top level of the five-point sharpen filter: config registers, position counters,
// line store, sample window and the arithmetic kernel.
// Depends on fpsf_pkg, fpsf_position, fpsf_line_store, fpsf_kernel.
//
// channel   handshake               payload
// sample    sample_valid/_stall     fpsf_in_t  (height_in, start_of_frame)
// result    result_valid/_stall     fpsf_out_t (height_out, column_out, row_out, last_of_run)
// cfg       cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One sample per clock while result_stall is low; a two-result sample holds the input back.
// From the accepting edge an item passes stencil, multiply and add/saturate stages, the last
// into the output register; the line store read shares the accepting edge.
// Reset clears counters, window and line store fill mark; no clearing pass is needed.
// result_stall holds the output register and backs up stage by stage to sample_stall.
`timescale 1ns / 1ps
`default_nettype none

module five_point_sharpen_filter_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            sample_valid,
	output logic                                 sample_stall,
	input  wire fpsf_pkg::fpsf_in_t              sample_item,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output fpsf_pkg::fpsf_out_t                  result_item,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fpsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fpsf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fpsf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic [FW_W-1:0]            frame_width_q;
	logic [FH_W-1:0]            frame_height_q;
	logic [STR_W-1:0]           strength_q;

	logic                       accept;
	logic                       adv1;
	logic [AW-1:0]              pos_x;
	logic [ROW_W-1:0]           pos_y;
	fpsf_flags_t                pos_flags;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [AW-1:0]              x_s1;
	logic [ROW_W-1:0]           y_s1;
	fpsf_flags_t                flags_s1;

	logic signed [SAMPLE_W-1:0] win0_q;
	logic signed [SAMPLE_W-1:0] win1_q;
	logic signed [SAMPLE_W-1:0] win2_q;
	logic signed [SAMPLE_W-1:0] prev_q;

	logic [PAIR_W-1:0]          rd_data;
	logic signed [SAMPLE_W-1:0] newer_c;
	logic signed [SAMPLE_W-1:0] older_c;
	logic                       has_result;
	logic                       k_ready;
	fpsf_kitem_t                k_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(1024);
			frame_height_q <= FH_W'(1024);
			strength_q     <= STR_W'(4096);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[FW_W-1:0];
				end
				CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[FH_W-1:0];
				end
				CFG_STRENGTH: begin
					strength_q <= cfg_data[STR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign has_result   = flags_s1.inner || flags_s1.border;
	assign adv1         = valid_s1 && (k_ready || !has_result);
	assign sample_stall = valid_s1 && !adv1;
	assign accept       = sample_valid && !sample_stall;

	fpsf_position #(
		.MAX_WIDTH(MAX_WIDTH),
		.AW(AW)
	) u_position (
		.clk(clk),
		.arst_n(arst_n),
		.advance(accept),
		.sof(sample_item.start_of_frame),
		.frame_width(frame_width_q),
		.frame_height(frame_height_q),
		.x(pos_x),
		.y(pos_y),
		.flags(pos_flags)
	);

	fpsf_line_store #(
		.DEPTH(MAX_WIDTH),
		.AW(AW)
	) u_line_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(pos_x),
		.wr_en(adv1),
		.wr_addr(x_s1),
		.wr_data({sample_s1, newer_c}),
		.rd_data(rd_data)
	);

	assign newer_c = rd_data[PAIR_W-1:SAMPLE_W];
	assign older_c = rd_data[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_item.height_in;
			x_s1      <= pos_x;
			y_s1      <= pos_y;
			flags_s1  <= pos_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			win0_q   <= '0;
			win1_q   <= '0;
			win2_q   <= '0;
			prev_q   <= '0;
		end else begin
			if (accept || adv1) begin
				valid_s1 <= accept;
			end
			if (adv1) begin
				win0_q <= win1_q;
				win1_q <= newer_c;
				win2_q <= older_c;
				prev_q <= sample_s1;
			end
		end
	end

	always_comb begin
		k_item.lap    = (LAP_W'(win1_q) <<< 2) -
			(LAP_W'(win0_q) + LAP_W'(newer_c) + LAP_W'(win2_q) + LAP_W'(prev_q));
		k_item.center = win1_q;
		k_item.sample = sample_s1;
		k_item.col    = COL_W'(x_s1);
		k_item.row    = y_s1;
		k_item.flags  = flags_s1;
	end

	fpsf_kernel u_kernel (
		.clk(clk),
		.arst_n(arst_n),
		.k_valid(valid_s1 && has_result),
		.k_ready(k_ready),
		.k_item(k_item),
		.strength(strength_q),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_five_point_sharpen_filter_unit.sv -----
// Testbench for five_point_sharpen_filter_unit: directed and random raster frames with
// random idling on both streams; a local sharpen predictor checks every result item.
// Depends on fpsf_pkg and the five_point_sharpen_filter_unit RTL.
`timescale 1ns / 1ps

module tb_five_point_sharpen_filter_unit;
	import fpsf_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int RANDOM_ITEMS  = 440;
	localparam int WIDE_EXTRA    = 16;
	localparam int TALL_ROWS     = 24;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int CYCLE_LIMIT   = 4000000;
	localparam int PRINT_LIMIT   = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	fpsf_in_t sample_item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	fpsf_out_t result_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic signed [SAMPLE_W-1:0] older_row [MAX_W] = '{default: '0};
	logic signed [SAMPLE_W-1:0] newer_row [MAX_W] = '{default: '0};
	logic signed [SAMPLE_W-1:0] win [3] = '{default: '0};
	int col_pos = 0;
	int row_pos = 0;
	logic [FW_W-1:0] width_reg = 11'd1024;
	logic [FH_W-1:0] height_reg = 13'd1024;
	logic [STR_W-1:0] strength_reg = 16'd4096;

	fpsf_out_t expected_pixels [$];
	bit idle_on = 1'b1;
	int error_count = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int settings_used = 0;
	int cycle_count = 0;

	five_point_sharpen_filter_unit #(.MAX_WIDTH(MAX_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_item(sample_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("MISMATCH: %s", msg);
		end
	endtask

	function automatic int draw_wait();
		return idle_on ? int'($urandom_range(0, 11)) : 0;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] draw_height();
		int v;
		v = $urandom_range(0, 1000);
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3, 4: return 16'(v - 500);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int eff_width();
		int w;
		w = width_reg;
		if (w < MIN_SIZE) w = MIN_SIZE;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int eff_height();
		int h;
		h = height_reg;
		if (h < MIN_SIZE) h = MIN_SIZE;
		if (h > MAX_ROWS) h = MAX_ROWS;
		return h;
	endfunction

	task automatic predict_sharpened(input fpsf_in_t it);
		int w, h, x, y;
		logic signed [SAMPLE_W-1:0] up2, up1;
		longint c, nb, lap, prod, r;
		bit border, inner;
		fpsf_out_t res;
		w = eff_width();
		h = eff_height();
		if (it.start_of_frame) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		x = col_pos;
		y = row_pos;
		up2 = older_row[x];
		up1 = newer_row[x];
		border = (x == 0) || (x == w - 1) || (y == 0) || (y == h - 1);
		inner = (x >= 2) && (y >= 2);
		if (inner) begin
			c = longint'(win[1]);
			nb = longint'(win[0]) + longint'(up1) + longint'(win[2])
				+ longint'(newer_row[x - 1]);
			lap = 4 * c - nb;
			prod = longint'(strength_reg) * lap;
			r = c + (prod >>> FRAC_W);
			if (r > 32767) r = 32767;
			else if (r < -32768) r = -32768;
			res.height_out = 16'(r);
			res.column_out = COL_W'(x - 1);
			res.row_out = ROW_W'(y - 1);
			res.last_of_run = !border;
			expected_pixels.push_back(res);
		end
		if (border) begin
			res.height_out = it.height_in;
			res.column_out = COL_W'(x);
			res.row_out = ROW_W'(y);
			res.last_of_run = 1'b1;
			expected_pixels.push_back(res);
		end
		win[0] = win[1];
		win[1] = up1;
		win[2] = up2;
		older_row[x] = up1;
		newer_row[x] = it.height_in;
		col_pos = x + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = y + 1;
			if (row_pos >= h) row_pos = 0;
		end
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] h, input bit sof);
		int gap;
		fpsf_in_t it;
		gap = draw_wait();
		it = '{height_in: h, start_of_frame: sof};
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_item <= it;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall !== 1'b0);
		predict_sharpened(it);
		samples_sent++;
	endtask

	// drop valid, wait out every expected result, then let the pipeline settle
	task automatic wait_idle();
		int guard;
		guard = 0;
		sample_valid <= 1'b0;
		while (expected_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input fpsf_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_FRAME_WIDTH: width_reg = d[FW_W-1:0];
			CFG_FRAME_HEIGHT: height_reg = d[FH_W-1:0];
			CFG_STRENGTH: strength_reg = d[STR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_filter(input logic [15:0] w_data, h_data, s_data);
		write_reg(CFG_FRAME_WIDTH, w_data);
		write_reg(CFG_FRAME_HEIGHT, h_data);
		write_reg(CFG_STRENGTH, s_data);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// receiver: hold stall for a drawn number of cycles before each item
	initial begin
		int hold;
		forever begin
			hold = draw_wait();
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!(result_valid === 1'b1 && result_stall === 1'b0));
		end
	end

	always @(posedge clk) begin : check_results
		fpsf_out_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			results_checked++;
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected result col %0d row %0d value %0d",
					result_item.column_out, result_item.row_out, result_item.height_out));
			end else begin
				want = expected_pixels.pop_front();
				if (result_item.height_out !== want.height_out)
					report_mismatch($sformatf("height_out %0d, want %0d at col %0d row %0d",
						result_item.height_out, want.height_out, want.column_out,
						want.row_out));
				if (result_item.column_out !== want.column_out)
					report_mismatch($sformatf("column_out %0d, want %0d",
						result_item.column_out, want.column_out));
				if (result_item.row_out !== want.row_out)
					report_mismatch($sformatf("row_out %0d, want %0d at col %0d",
						result_item.row_out, want.row_out, want.column_out));
				if (result_item.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %0b, want %0b at col %0d row %0d",
						result_item.last_of_run, want.last_of_run, want.column_out,
						want.row_out));
			end
		end
	end

	task automatic test_reset_defaults();
		idle_on = 1'b1;
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
	endtask

	// 3x3 frames with an extreme center against opposite extremes; second frame by wrap
	task automatic test_saturation_frames();
		int k;
		wait_idle();
		program_filter(16'd0, 16'd1, 16'hFFFF);
		for (k = 0; k < 18; k++) begin
			if (k < 9)
				send_sample((k == 4) ? 16'sh7FFF : 16'sh8000, k == 0);
			else
				send_sample((k == 13) ? 16'sh8000 : 16'sh7FFF, 1'b0);
		end
	endtask

	// shrink the width while the column counter sits past it
	task automatic test_resize_midframe();
		int k;
		wait_idle();
		program_filter(16'd4, 16'd8, 16'd4096);
		for (k = 0; k < 7; k++) send_sample(draw_height(), k == 0);
		wait_idle();
		program_filter(16'd3, 16'd3, 16'd2048);
		for (k = 0; k < 3; k++) send_sample(draw_height(), 1'b0);
	endtask

	task automatic test_widest_row();
		int k;
		wait_idle();
		idle_on = 1'b0;
		program_filter(16'hFFFF, 16'd3, 16'($urandom));
		for (k = 0; k < MAX_W + WIDE_EXTRA; k++) send_sample(draw_height(), k == 0);
	endtask

	task automatic test_tallest_frame();
		int k;
		wait_idle();
		idle_on = 1'b0;
		program_filter(16'd3, 16'hFFFF, 16'd4096);
		for (k = 0; k < 3 * TALL_ROWS; k++) send_sample(draw_height(), k == 0);
	endtask

	task automatic test_random_frames();
		int fw, fh, fs, size, n, k, sent;
		bit fresh, sof;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			idle_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: fw = $urandom_range(0, 2);
				1: fw = $urandom_range(1025, 2047);
				2: fw = $urandom_range(13, 40);
				default: fw = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 9))
				0: fh = $urandom_range(0, 2);
				1: fh = $urandom_range(4097, 8191);
				default: fh = $urandom_range(3, 10);
			endcase
			case ($urandom_range(0, 5))
				0: fs = 0;
				1: fs = 16'hFFFF;
				2: fs = 4096;
				default: fs = $urandom_range(0, 65535);
			endcase
			if ($urandom_range(0, 3) == 0) fw = fw | ($urandom_range(1, 31) << FW_W);
			if ($urandom_range(0, 3) == 0) fh = fh | ($urandom_range(1, 7) << FH_W);
			program_filter(16'(fw), 16'(fh), 16'(fs));
			size = eff_width() * eff_height();
			fresh = ($urandom_range(0, 4) != 0);
			if (size > 200) n = $urandom_range(5, 60);
			else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, size);
			else n = size * $urandom_range(1, 3);
			for (k = 0; k < n; k++) begin
				sof = (k == 0 && fresh) || (fresh && k % size == 0 && $urandom_range(0, 1))
					|| ($urandom_range(0, 299) == 0);
				if ($urandom_range(0, 149) == 0) wait_idle();
				send_sample(draw_height(), sof);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_saturation_frames();
		test_resize_midframe();
		test_widest_row();
		test_tallest_frame();
		test_random_frames();
		wait_idle();
		if (expected_pixels.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_pixels.size()));
		$display("Sent %0d samples over %0d size/strength settings, checked %0d results.",
			samples_sent, settings_used, results_checked);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
